[sv/tgs_pkg.sv]
// Shared constants, codes and types for the turmite grid stepper.
package tgs_pkg;

  // Grid geometry
  localparam int unsigned GridSide  = 32;
  localparam int unsigned CellCount = GridSide * GridSide;
  localparam int unsigned IdxW      = $clog2(CellCount);
  localparam int unsigned CellW     = 2;
  localparam int unsigned DirW      = 2;
  localparam int unsigned StepW     = 48;
  localparam int unsigned RuleW     = 12;
  localparam int unsigned RuleEntW  = 3;

  localparam logic [IdxW-1:0]  StartIndex = IdxW'(CellCount / 2 + GridSide / 2);
  localparam logic [IdxW-1:0]  SideStep   = IdxW'(GridSide % CellCount);
  localparam logic [RuleW-1:0] RuleReset  = RuleW'(1962);

  // Result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Stream widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 64;

  typedef enum logic [DirW-1:0] {
    DirRight = 2'd0,
    DirUp    = 2'd1,
    DirLeft  = 2'd2,
    DirDown  = 2'd3
  } dir_e;

  typedef enum logic {
    OpStep = 1'b0,
    OpRead = 1'b1
  } op_e;

  // One result; ant_position sits in the lowest bits
  typedef struct packed {
    logic [StepW-1:0] step_count;
    logic [CellW-1:0] cell_value;
    logic [DirW-1:0]  ant_direction;
    logic [IdxW-1:0]  ant_position;
  } tgs_result_t;

  localparam int unsigned ResultW = $bits(tgs_result_t);

endpackage

[sv/turmite_grid_step.sv]
// Turmite grid stepper: top level with ant state, rule register and update stage.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         s_axis_tvalid/tready      tuser: opcode; tdata: read_index
//  m_axis    out        m_axis_tvalid/tready      tdata: position, direction, cell, steps
//  rule      in         rule_we_i                 rule_wdata_i: rule_table
//
// A read request is issued to the cell memory in the cycle it is accepted and
// its result is formed in the cycle after; reads follow each other every cycle
// while the result queue has room. A step request holds off the next request
// while the cell is read, decoded and written back, so steps never go back to back.
// After reset the memory is swept to zero; no request is taken then.
// A four-entry result queue keeps requests flowing while m_axis is stalled.
module turmite_grid_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tgs_pkg::InDataW-1:0]    s_axis_tdata,   // [9:0] read_index, rest zero
  input  logic                           s_axis_tuser,   // [0] opcode
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tgs_pkg::OutDataW-1:0]   m_axis_tdata,   // [9:0] ant_position,
                                                         // [11:10] ant_direction,
                                                         // [13:12] cell_value,
                                                         // [61:14] step_count
  // rule register
  input  logic                           rule_we_i,
  input  logic [tgs_pkg::RuleW-1:0]      rule_wdata_i
);
  import tgs_pkg::*;

  // architectural state
  logic [RuleW-1:0] rule_q;
  logic [IdxW-1:0]  pos_q, pos_d;
  dir_e             head_q, head_d;
  logic [StepW-1:0] steps_q, steps_d;

  // clearing sweep
  logic [IdxW:0]    clr_cnt_q;
  logic             clearing;

  // update stage
  logic             s1_valid_q;
  logic             s1_step_q;
  logic [IdxW-1:0]  s1_addr_q;

  logic             accept;
  op_e              req_op;
  logic [IdxW-1:0]  req_index;
  logic [IdxW-1:0]  moved;
  logic [IdxW-1:0]  rd_addr;
  logic [CellW-1:0] cell_rd;

  logic [RuleEntW-1:0] rule_ent;
  logic [CellW-1:0]    next_cell;
  dir_e                turned;
  logic                s1_write;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;

  tgs_result_t         result;
  tgs_result_t         fifo_head;
  logic [FifoCntW-1:0] fifo_count;
  logic                space_ok;

  assign req_op    = op_e'(s_axis_tuser);
  assign req_index = s_axis_tdata[IdxW-1:0];
  assign clearing  = ~clr_cnt_q[IdxW];

  // room for the in-flight result plus the one accepted now
  assign space_ok = ({1'b0, fifo_count} + {{FifoCntW{1'b0}}, s1_valid_q})
                    < (FifoCntW+1)'(FifoDepth);

  // a step in the update stage blocks the next request
  assign s_axis_tready = ~clearing & ~(s1_valid_q & s1_step_q) & space_ok;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // neighbor cell along the heading, wrapping over the flat index
  always_comb begin
    unique case (head_q)
      DirRight: moved = pos_q + IdxW'(1);
      DirUp:    moved = pos_q - SideStep;
      DirLeft:  moved = pos_q - IdxW'(1);
      DirDown:  moved = pos_q + SideStep;
      default:  moved = pos_q;
    endcase
  end

  assign rd_addr = (req_op == OpStep) ? moved : req_index;

  // rule lookup for the cell just read
  always_comb begin
    unique case (cell_rd)
      2'd0:    rule_ent = rule_q[2:0];
      2'd1:    rule_ent = rule_q[5:3];
      2'd2:    rule_ent = rule_q[8:6];
      default: rule_ent = rule_q[11:9];
    endcase
  end

  assign next_cell = rule_ent[2:1];
  assign turned    = rule_ent[0] ? dir_e'(head_q + DirW'(1)) : dir_e'(head_q - DirW'(1));
  assign s1_write  = s1_valid_q & s1_step_q;

  // memory write: clearing sweep or step write-back
  assign mem_we    = clearing | s1_write;
  assign mem_waddr = clearing ? clr_cnt_q[IdxW-1:0] : s1_addr_q;

  tgs_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (clearing ? CellW'(0) : next_cell),
    .raddr_i (rd_addr),
    .rdata_o (cell_rd)
  );

  // state updates
  always_comb begin
    pos_d   = pos_q;
    head_d  = head_q;
    steps_d = steps_q;
    if (accept && req_op == OpStep) begin
      pos_d = moved;
    end
    if (s1_write) begin
      head_d  = turned;
      steps_d = steps_q + StepW'(1);
    end
  end

  // result of the item in the update stage
  always_comb begin
    result.ant_position  = pos_q;
    result.ant_direction = s1_step_q ? turned : head_q;
    result.cell_value    = s1_step_q ? next_cell : cell_rd;
    result.step_count    = s1_step_q ? steps_q + StepW'(1) : steps_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q     <= RuleReset;
      pos_q      <= StartIndex;
      head_q     <= DirRight;
      steps_q    <= '0;
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      s1_step_q  <= 1'b0;
    end else begin
      if (rule_we_i) begin
        rule_q <= rule_wdata_i;
      end
      pos_q      <= pos_d;
      head_q     <= head_d;
      steps_q    <= steps_d;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + (IdxW+1)'(1);
      end
      s1_valid_q <= accept;
      s1_step_q  <= accept & (req_op == OpStep);
    end
  end

  // cell address held for write-back
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= rd_addr;
    end
  end

  tgs_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (result),
    .valid_o     (m_axis_tvalid),
    .pop_i       (m_axis_tready),
    .data_o      (fifo_head),
    .count_o     (fifo_count)
  );

  assign m_axis_tdata = {(OutDataW-ResultW)'(0), fifo_head};

endmodule

[sv/tgs_ram.sv]
// Grid cell memory: one write port, one read port, registered read data.
module tgs_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [tgs_pkg::IdxW-1:0]   waddr_i,
  input  logic [tgs_pkg::CellW-1:0]  wdata_i,
  input  logic [tgs_pkg::IdxW-1:0]   raddr_i,
  output logic [tgs_pkg::CellW-1:0]  rdata_o
);
  import tgs_pkg::*;

  logic [CellW-1:0] mem [CellCount];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/tgs_out_fifo.sv]
// Small result queue between the update stage and the output stream.
module tgs_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tgs_pkg::tgs_result_t  push_data_i,
  output logic                  valid_o,
  input  logic                  pop_i,
  output tgs_pkg::tgs_result_t  data_o,
  output logic [tgs_pkg::FifoCntW-1:0] count_o
);
  import tgs_pkg::*;

  tgs_result_t         entries_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i & valid_o;
  assign data_o  = entries_q[rd_ptr_q];
  assign count_o = count_q;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + FifoCntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sim/turmite_grid_step_test.sv]
// Self-checking stream testbench for the turmite grid stepper.
module turmite_grid_step_test;
  import tgs_pkg::*;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned HoldCycles   = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                rule_we_i;
  logic [RuleW-1:0]    rule_wdata_i;

  turmite_grid_step u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .rule_we_i     (rule_we_i),
    .rule_wdata_i  (rule_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Expected ant and grid state, kept in step with accepted requests
  logic [CellW-1:0] cell_grid [CellCount];
  logic [IdxW-1:0]  ant_pos;
  dir_e             ant_heading;
  logic [StepW-1:0] steps_done;
  logic [RuleW-1:0] rule_q;
  tgs_result_t      pending_results [$];

  int unsigned errors       = 0;
  int unsigned steps_sent   = 0;
  int unsigned reads_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned rule_writes  = 0;
  bit          gaps_on      = 1'b1;
  bit          stalls_on    = 1'b1;
  int unsigned rx_hold_cycles = 0;

  // Apply one request to the expected state and return the result it yields
  function automatic tgs_result_t apply_turmite_request(input op_e op,
                                                        input logic [IdxW-1:0] idx);
    logic [CellW-1:0]    cur;
    logic [RuleEntW-1:0] entry;
    tgs_result_t         res;
    if (op == OpStep) begin
      // move first; 10-bit arithmetic wraps over the whole grid
      case (ant_heading)
        DirRight: ant_pos = ant_pos + IdxW'(1);
        DirUp:    ant_pos = ant_pos - SideStep;
        DirLeft:  ant_pos = ant_pos - IdxW'(1);
        default:  ant_pos = ant_pos + SideStep;
      endcase
      cur   = cell_grid[ant_pos];
      entry = rule_q[RuleEntW*cur +: RuleEntW];
      if (entry[0]) begin
        ant_heading = dir_e'(ant_heading + 2'd1);
      end else begin
        ant_heading = dir_e'(ant_heading - 2'd1);
      end
      cell_grid[ant_pos] = entry[2:1];
      steps_done         = steps_done + StepW'(1);
      res.cell_value     = entry[2:1];
    end else begin
      res.cell_value = cell_grid[idx];
    end
    res.ant_position  = ant_pos;
    res.ant_direction = ant_heading;
    res.step_count    = steps_done;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [StepW-1:0] want,
                             input logic [StepW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result sink: checks every accepted result and drives tready with stalls
  initial begin : result_sink
    tgs_result_t got;
    tgs_result_t want;
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = tgs_result_t'(m_axis_tdata[ResultW-1:0]);
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result %h with nothing expected", $time, got);
        end else begin
          want = pending_results.pop_front();
          check_field("ant_position", StepW'(want.ant_position),
                      StepW'(got.ant_position));
          check_field("ant_direction", StepW'(want.ant_direction),
                      StepW'(got.ant_direction));
          check_field("cell_value", StepW'(want.cell_value), StepW'(got.cell_value));
          check_field("step_count", want.step_count, got.step_count);
        end
      end
      // long hold first, then random stall bursts
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one request and wait for it to be taken; tvalid stays high afterwards
  task automatic send_request(input op_e op, input logic [IdxW-1:0] idx);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= InDataW'(idx);
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_results.push_back(apply_turmite_request(op, idx));
    if (op == OpStep) begin
      steps_sent++;
    end else begin
      reads_sent++;
    end
  endtask

  task automatic send_random_request();
    op_e             op;
    logic [IdxW-1:0] idx;
    op = ($urandom_range(0, 9) < 6) ? OpStep : OpRead;
    // reads near the ant see cells that actually changed
    case ($urandom_range(0, 3))
      0:       idx = ant_pos + IdxW'($urandom_range(0, 8)) - IdxW'(4);
      1:       idx = ($urandom_range(0, 1) != 0) ? IdxW'(CellCount - 1) : '0;
      default: idx = IdxW'($urandom);
    endcase
    send_request(op, idx);
  endtask

  // Stop offering, wait for every expected result, then let the block settle
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      pending_results.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_rule(input logic [RuleW-1:0] value);
    drain_results();
    rule_we_i    <= 1'b1;
    rule_wdata_i <= value;
    @(posedge clk_i);
    rule_we_i <= 1'b0;
    rule_q = value;
    rule_writes++;
  endtask

  // Cleared grid and start position straight after reset
  task automatic test_reset_state();
    send_request(OpRead, '0);
    send_request(OpRead, IdxW'(CellCount - 1));
    send_request(OpRead, StartIndex);
    send_request(OpRead, IdxW'(StartIndex + 1));
  endtask

  // A few steps under the reset rule, then read back visited cells
  task automatic test_default_rule();
    repeat (8) send_request(OpStep, IdxW'($urandom));
    send_request(OpRead, ant_pos);
    send_request(OpRead, IdxW'(StartIndex + 1));
  endtask

  // All-right/state-0 rule and all-left/state-3 rule
  task automatic test_rule_extremes();
    write_rule('0);
    repeat (4) send_request(OpStep, '1);
    send_request(OpRead, ant_pos);
    write_rule('1);
    repeat (5) send_request(OpStep, '0);
    send_request(OpRead, ant_pos);
  endtask

  // Phases of random traffic, each under its own rule and idling mix
  task automatic test_random_traffic(input int unsigned phases,
                                     input int unsigned per_phase);
    for (int unsigned p = 0; p < phases; p++) begin
      write_rule((p == phases - 1) ? RuleReset : RuleW'($urandom_range(0, 4095)));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat (per_phase) send_random_request();
    end
  endtask

  // Long output hold while requests keep coming, so the block stalls its input
  task automatic test_backpressure();
    drain_results();
    gaps_on        = 1'b0;
    rx_hold_cycles = HoldCycles;
    repeat (24) send_random_request();
    drain_results();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_steady_flow(input int unsigned count);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (count) send_random_request();
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpStep;
    rule_we_i     <= 1'b0;
    rule_wdata_i  <= '0;
    foreach (cell_grid[i]) cell_grid[i] = '0;
    ant_pos     = StartIndex;
    ant_heading = DirRight;
    steps_done  = '0;
    rule_q      = RuleReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_default_rule();
    test_rule_extremes();
    test_random_traffic(6, 250);
    test_backpressure();
    test_steady_flow(400);
    drain_results();

    $display("Checked %0d results: %0d steps, %0d cell reads, %0d rule writes.",
             results_seen, steps_sent, reads_sent, rule_writes);
    $display("Covered reset state, extreme and random rules, output stalls and gaps.");
    if (errors == 0) begin
      $display("turmite_grid_step_test passed");
    end else begin
      $display("turmite_grid_step_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
    $display("turmite_grid_step_test failed");
    $finish;
  end

endmodule

[filelist.f]
sv/tgs_pkg.sv
sv/tgs_ram.sv
sv/tgs_out_fifo.sv
sv/turmite_grid_step.sv
sim/turmite_grid_step_test.sv
